// ----- rtl/core/psch_pkg.sv -----
// Shared types and constants for the preemptive priority scheduler.
// Used by the channel interfaces, the controller, the datapath and the top level.
package psch_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W   = 8;
    localparam int TIME_W = 32;
    localparam int BURST_W = 16;
    localparam int PRIO_W = 8;

    // request codes carried in req_type
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } psch_state_t;

    typedef struct packed {
        logic load;    // write the request beat into the next free slot
        logic start;   // tick accepted: clear the best-so-far
        logic step;    // examine the slot under the scan index
        logic commit;  // run the chosen task and register the result
    } psch_cmd_t;

    typedef struct packed {
        logic scan_last;    // scan index sits on the last loaded slot
        logic table_empty;  // nothing loaded
        logic out_free;     // result register can take a beat this cycle
    } psch_sts_t;

endpackage

// ----- rtl/core/psch_if.sv -----
// Request and result channel interfaces (valid/ready) for the scheduler.
// Depends on psch_pkg for field widths.
interface psch_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [psch_pkg::ID_W-1:0]    task_id;
    logic [psch_pkg::TIME_W-1:0]  arrival_tick;
    logic [psch_pkg::BURST_W-1:0] burst_ticks;
    logic [psch_pkg::PRIO_W-1:0]  prio_level;

    modport source (output valid, req_type, task_id, arrival_tick, burst_ticks, prio_level,
                    input ready);
    modport sink (input valid, req_type, task_id, arrival_tick, burst_ticks, prio_level,
                  output ready);
endinterface

interface psch_res_if;
    logic                        valid;
    logic                        ready;
    logic [psch_pkg::ID_W-1:0]   run_task_id;
    logic                        busy_res;
    logic                        segment_start;
    logic                        task_finished;
    logic [psch_pkg::TIME_W-1:0] turnaround_ticks;
    logic [psch_pkg::TIME_W-1:0] waiting_ticks;
    logic                        all_done;
    logic [psch_pkg::TIME_W-1:0] tick_now;

    modport source (output valid, run_task_id, busy_res, segment_start, task_finished,
                    turnaround_ticks, waiting_ticks, all_done, tick_now,
                    input ready);
    modport sink (input valid, run_task_id, busy_res, segment_start, task_finished,
                  turnaround_ticks, waiting_ticks, all_done, tick_now,
                  output ready);
endinterface

// ----- rtl/core/preemptive_priority_scheduler.sv -----
// Preemptive priority scheduler top level: controller plus datapath.
// Load beat: written into the next free slot unless the table is full, no result. Tick beat:
// one table slot examined per cycle (no scan on an empty table), then a commit state that waits
// until the result register is free; the result is registered at commit, then back to idle.
// The next beat is taken once the result is registered, even if it waits downstream.
// rst_n (async, active low) empties the table and zeroes time; slot data is not cleared.
module preemptive_priority_scheduler (
    input logic      clk,
    input logic      rst_n,
    psch_req_if.sink task_req,
    psch_res_if.source sched_res
);

    psch_pkg::psch_cmd_t cmd;
    psch_pkg::psch_sts_t sts;

    psch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (task_req.valid),
        .req_type (task_req.req_type),
        .in_ready (task_req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    psch_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .task_id          (task_req.task_id),
        .arrival_tick     (task_req.arrival_tick),
        .burst_ticks      (task_req.burst_ticks),
        .prio_level       (task_req.prio_level),
        .out_ready        (sched_res.ready),
        .out_valid        (sched_res.valid),
        .run_task_id      (sched_res.run_task_id),
        .busy_res         (sched_res.busy_res),
        .segment_start    (sched_res.segment_start),
        .task_finished    (sched_res.task_finished),
        .turnaround_ticks (sched_res.turnaround_ticks),
        .waiting_ticks    (sched_res.waiting_ticks),
        .all_done         (sched_res.all_done),
        .tick_now         (sched_res.tick_now)
    );

endmodule

// ----- rtl/core/psch_ctrl.sv -----
// Scheduler controller: idle / scan / commit sequencing.
// Depends on psch_pkg for the state type and command/status structs.
module psch_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                req_type,
    output logic                in_ready,
    input  psch_pkg::psch_sts_t sts,
    output psch_pkg::psch_cmd_t cmd
);

    psch_pkg::psch_state_t state_reg;
    psch_pkg::psch_state_t state_next;
    logic                  accept;

    assign accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psch_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            psch_pkg::ST_IDLE:
            begin
                if (accept && req_type == psch_pkg::REQ_TICK)
                begin
                    state_next = sts.table_empty ? psch_pkg::ST_COMMIT : psch_pkg::ST_SCAN;
                end
            end
            psch_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = psch_pkg::ST_COMMIT;
                end
            end
            psch_pkg::ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = psch_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = psch_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = (state_reg == psch_pkg::ST_IDLE);
        cmd.load   = accept && (req_type == psch_pkg::REQ_LOAD);
        cmd.start  = accept && (req_type == psch_pkg::REQ_TICK);
        cmd.step   = (state_reg == psch_pkg::ST_SCAN);
        cmd.commit = (state_reg == psch_pkg::ST_COMMIT) && sts.out_free;
    end

endmodule

// ----- rtl/core/psch_dp.sv -----
// Scheduler datapath: task table, scan comparator, timekeeping and result register.
// Depends on psch_pkg; driven by psch_ctrl through command/status structs.
module psch_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  psch_pkg::psch_cmd_t          cmd,
    output psch_pkg::psch_sts_t          sts,
    input  logic [psch_pkg::ID_W-1:0]    task_id,
    input  logic [psch_pkg::TIME_W-1:0]  arrival_tick,
    input  logic [psch_pkg::BURST_W-1:0] burst_ticks,
    input  logic [psch_pkg::PRIO_W-1:0]  prio_level,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [psch_pkg::ID_W-1:0]    run_task_id,
    output logic                         busy_res,
    output logic                         segment_start,
    output logic                         task_finished,
    output logic [psch_pkg::TIME_W-1:0]  turnaround_ticks,
    output logic [psch_pkg::TIME_W-1:0]  waiting_ticks,
    output logic                         all_done,
    output logic [psch_pkg::TIME_W-1:0]  tick_now
);

    localparam int N  = psch_pkg::MAX_TASKS;
    localparam int IW = psch_pkg::IDX_W;
    localparam int CW = psch_pkg::CNT_W;
    localparam int TW = psch_pkg::TIME_W;
    localparam int BW = psch_pkg::BURST_W;

    // task table
    logic [psch_pkg::ID_W-1:0]   id_reg    [N];
    logic [TW-1:0]               arr_reg   [N];
    logic [BW-1:0]               burst_reg [N];
    logic [BW-1:0]               rem_reg   [N];
    logic [psch_pkg::PRIO_W-1:0] prio_reg  [N];
    logic [N-1:0]                done_reg;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] done_cnt_reg;
    logic [TW-1:0] time_reg;
    logic [IW-1:0] cur_slot_reg;
    logic          cur_valid_reg;
    logic [IW-1:0] idx_reg;

    // best candidate seen so far in this scan
    logic                        found_reg;
    logic [IW-1:0]               best_slot_reg;
    logic [psch_pkg::PRIO_W-1:0] best_prio_reg;
    logic [BW-1:0]               best_rem_reg;
    logic [psch_pkg::ID_W-1:0]   best_id_reg;
    logic [TW-1:0]               best_arr_reg;
    logic [BW-1:0]               best_burst_reg;

    logic          out_valid_reg;
    logic          table_full;
    logic [IW-1:0] load_slot;
    logic          eligible;
    logic          beats;
    logic          finish;
    logic [TW-1:0] tat;
    logic [TW-1:0] wait_t;
    logic [CW-1:0] done_cnt_next;
    logic [CW-1:0] last_slot;

    assign table_full = (count_reg == CW'(N));
    assign load_slot  = count_reg[IW-1:0];
    assign last_slot  = count_reg - CW'(1);

    assign sts.scan_last   = ({{(CW-IW){1'b0}}, idx_reg} == last_slot);
    assign sts.table_empty = (count_reg == '0);
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign eligible = !done_reg[idx_reg] && (arr_reg[idx_reg] <= time_reg);
    // strict compares keep the lower slot on a full tie
    assign beats = !found_reg
                || (prio_reg[idx_reg] < best_prio_reg)
                || ((prio_reg[idx_reg] == best_prio_reg) && (rem_reg[idx_reg] < best_rem_reg));

    assign finish        = found_reg && (best_rem_reg <= BW'(1));
    assign tat           = time_reg + TW'(1) - best_arr_reg;
    assign wait_t        = tat - {{(TW-BW){1'b0}}, best_burst_reg};
    assign done_cnt_next = done_cnt_reg + CW'(finish);

    // table payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load && !table_full)
        begin
            id_reg[load_slot]    <= task_id;
            arr_reg[load_slot]   <= arrival_tick;
            burst_reg[load_slot] <= burst_ticks;
            rem_reg[load_slot]   <= burst_ticks;
            prio_reg[load_slot]  <= prio_level;
        end
        else if (cmd.commit && found_reg)
        begin
            rem_reg[best_slot_reg] <= finish ? '0 : best_rem_reg - BW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && eligible && beats)
        begin
            best_slot_reg  <= idx_reg;
            best_prio_reg  <= prio_reg[idx_reg];
            best_rem_reg   <= rem_reg[idx_reg];
            best_id_reg    <= id_reg[idx_reg];
            best_arr_reg   <= arr_reg[idx_reg];
            best_burst_reg <= burst_reg[idx_reg];
        end
        if (cmd.commit)
        begin
            run_task_id      <= found_reg ? best_id_reg : '0;
            busy_res         <= found_reg;
            segment_start    <= found_reg && (!cur_valid_reg || cur_slot_reg != best_slot_reg);
            task_finished    <= finish;
            turnaround_ticks <= finish ? tat : '0;
            waiting_ticks    <= finish ? wait_t : '0;
            all_done         <= (done_cnt_next == count_reg);
            tick_now         <= time_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            count_reg     <= '0;
            done_cnt_reg  <= '0;
            time_reg      <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && !table_full)
            begin
                done_reg[load_slot] <= 1'b0;
                count_reg           <= count_reg + CW'(1);
            end

            if (cmd.start)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_reg + IW'(1);
                if (eligible)
                begin
                    found_reg <= 1'b1;
                end
            end

            if (cmd.commit)
            begin
                time_reg     <= time_reg + TW'(1);
                done_cnt_reg <= done_cnt_next;
                if (found_reg)
                begin
                    cur_slot_reg  <= best_slot_reg;
                    cur_valid_reg <= !finish;
                    if (finish)
                    begin
                        done_reg[best_slot_reg] <= 1'b1;
                    end
                end
            end

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule
